>>> rtl/core/dbd_pkg.sv
// Package for the delimiter byte deframer: shared types and constants.
// Used by dbd_engine and delimiter_byte_deframer; depends on nothing.
package dbd_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned MINLEN_W = 12;
    localparam int unsigned ADDR_W   = 5;

    // Register indexes, taken from paddr[4:2].
    typedef enum logic [2:0] {
        REG_USE_START = 3'd0,
        REG_START     = 3'd1,
        REG_USE_END   = 3'd2,
        REG_END       = 3'd3,
        REG_MIN_LEN   = 3'd4
    } reg_idx_t;

    typedef struct packed {
        logic                use_start;
        logic [BYTE_W-1:0]   start_delim;
        logic                use_end;
        logic [BYTE_W-1:0]   end_delim;
        logic [MINLEN_W-1:0] min_len;
    } dbd_cfg_t;

    typedef struct packed {
        logic              emit;
        logic [BYTE_W-1:0] data;
        logic              last;
    } dbd_result_t;

endpackage

>>> rtl/core/dbd_engine.sv
// Framing engine: frame state, held byte and length count, plus the per-byte decision.
// Depends on dbd_pkg.
module dbd_engine #(
    parameter int unsigned LENGTH_BITS = 12
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  dbd_pkg::dbd_cfg_t          cfg,
    input  logic                       accept,
    input  logic [dbd_pkg::BYTE_W-1:0] rx_byte,
    output dbd_pkg::dbd_result_t       res
);

    localparam int unsigned CMP_W = (LENGTH_BITS > dbd_pkg::MINLEN_W) ?
                                    LENGTH_BITS : dbd_pkg::MINLEN_W;
    localparam logic [LENGTH_BITS-1:0] COUNT_MAX = {LENGTH_BITS{1'b1}};
    localparam logic [LENGTH_BITS-1:0] COUNT_ONE = LENGTH_BITS'(1);

    logic                       in_frame_reg, in_frame_next;
    logic [dbd_pkg::BYTE_W-1:0] held_byte_reg, held_byte_next;
    logic                       held_valid_reg, held_valid_next;
    logic [LENGTH_BITS-1:0]     len_reg, len_next;

    logic                   is_start, is_end;
    logic [LENGTH_BITS-1:0] len_inc;
    logic [CMP_W-1:0]       len_ext, len_inc_ext, min_ext, need_ext;

    assign is_start    = cfg.use_start && (rx_byte == cfg.start_delim);
    assign is_end      = cfg.use_end && (rx_byte == cfg.end_delim);
    assign len_inc     = (len_reg == COUNT_MAX) ? len_reg : len_reg + COUNT_ONE;
    assign len_ext     = CMP_W'(len_reg);
    assign len_inc_ext = CMP_W'(len_inc);
    assign min_ext     = CMP_W'(cfg.min_len);
    // zero minimum counts as one in start-only mode
    assign need_ext    = (cfg.min_len == '0) ? CMP_W'(1) : min_ext;

    always_comb begin
        in_frame_next   = in_frame_reg;
        held_byte_next  = held_byte_reg;
        held_valid_next = 1'b0;
        len_next        = len_reg;
        res.emit        = 1'b0;
        res.data        = rx_byte;
        res.last        = 1'b0;
        if (!cfg.use_start && !cfg.use_end) begin
            res.emit = 1'b1;
            res.last = 1'b1;
        end else if (cfg.use_start && !cfg.use_end) begin
            held_valid_next = held_valid_reg;
            if (!in_frame_reg) begin
                if (is_start) begin
                    in_frame_next   = 1'b1;
                    held_byte_next  = rx_byte;
                    held_valid_next = 1'b1;
                    len_next        = COUNT_ONE;
                end
            end else begin
                // release the held byte, hold the new one
                res.emit        = held_valid_reg;
                res.data        = held_byte_reg;
                res.last        = is_start && (len_ext >= need_ext);
                held_byte_next  = rx_byte;
                held_valid_next = 1'b1;
                len_next        = res.last ? COUNT_ONE : len_inc;
            end
        end else if (!cfg.use_start) begin
            res.emit = 1'b1;
            res.last = is_end && (len_inc_ext >= min_ext);
            len_next = res.last ? '0 : len_inc;
        end else begin
            if (!in_frame_reg) begin
                if (is_start) begin
                    in_frame_next = 1'b1;
                    len_next      = '0;
                    res.emit      = 1'b1;
                end
            end else begin
                res.emit = 1'b1;
                if (is_end && (len_ext >= min_ext)) begin
                    in_frame_next = 1'b0;
                    len_next      = '0;
                    res.last      = 1'b1;
                end else begin
                    len_next = len_inc;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_frame_reg   <= 1'b0;
            held_byte_reg  <= '0;
            held_valid_reg <= 1'b0;
            len_reg        <= '0;
        end else if (accept) begin
            in_frame_reg   <= in_frame_next;
            held_byte_reg  <= held_byte_next;
            held_valid_reg <= held_valid_next;
            len_reg        <= len_next;
        end
    end

endmodule

>>> rtl/core/delimiter_byte_deframer.sv
// Delimiter byte deframer: each accepted request's result is registered and shows in the cycle
// after it (start-only mode releases each byte on the following request). Throughput one
// request per cycle, set by the single output register; s_tready drops only while
// that register holds a result the sink has not taken. Synchronous active-low
// reset clears configuration, frame state and the output valid. Depends on dbd_pkg, dbd_engine.
module delimiter_byte_deframer #(
    parameter int unsigned LENGTH_BITS = 12
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    // input stream
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [7:0]                  s_tdata,   // [7:0] rx_byte
    // result stream
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [7:0]                  m_tdata,   // [7:0] frame_byte
    output logic                        m_tlast,   // frame_last
    // configuration port
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [dbd_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);

    dbd_pkg::dbd_cfg_t    cfg_reg;
    dbd_pkg::dbd_result_t res;
    dbd_pkg::reg_idx_t    reg_idx;

    logic       accept;
    logic       cfg_we;
    logic       m_valid_reg;
    logic [7:0] m_data_reg;
    logic       m_last_reg;

    // ---------------------------------------------------------------
    // Configuration registers: written on the access phase of a write.
    // ---------------------------------------------------------------
    assign pready  = 1'b1;
    assign cfg_we  = psel && penable && pwrite && pready;
    assign reg_idx = dbd_pkg::reg_idx_t'(paddr[4:2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (cfg_we) begin
            unique case (reg_idx)
                dbd_pkg::REG_USE_START: cfg_reg.use_start   <= pwdata[0];
                dbd_pkg::REG_START:     cfg_reg.start_delim <= pwdata[7:0];
                dbd_pkg::REG_USE_END:   cfg_reg.use_end     <= pwdata[0];
                dbd_pkg::REG_END:       cfg_reg.end_delim   <= pwdata[7:0];
                dbd_pkg::REG_MIN_LEN:   cfg_reg.min_len     <= pwdata[11:0];
                default: ;  // addresses past the register list are ignored
            endcase
        end
    end

    // Read back: zero-extend each register into the data word.
    always_comb begin
        unique case (reg_idx)
            dbd_pkg::REG_USE_START: prdata = 32'(cfg_reg.use_start);
            dbd_pkg::REG_START:     prdata = 32'(cfg_reg.start_delim);
            dbd_pkg::REG_USE_END:   prdata = 32'(cfg_reg.use_end);
            dbd_pkg::REG_END:       prdata = 32'(cfg_reg.end_delim);
            dbd_pkg::REG_MIN_LEN:   prdata = 32'(cfg_reg.min_len);
            default:                prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------
    // Input handshake: take a request whenever the output register is
    // empty or is being drained this cycle.
    // ---------------------------------------------------------------
    assign s_tready = !m_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    dbd_engine #(
        .LENGTH_BITS(LENGTH_BITS)
    ) u_engine (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg_reg),
        .accept  (accept),
        .rx_byte (s_tdata),
        .res     (res)
    );

    // ---------------------------------------------------------------
    // Output register: load on an accepted request that emits a byte,
    // drop the valid once the sink takes the result.
    // ---------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (accept) begin
            m_valid_reg <= res.emit;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && res.emit) begin
            m_data_reg <= res.data;
            m_last_reg <= res.last;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    a_stall_only_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid)
        else $error("input stalled with an empty output register");

    a_plain_mode_passes: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && !cfg_reg.use_start && !cfg_reg.use_end) |=> (m_tvalid && m_tlast))
        else $error("byte without delimiters not passed as a one-byte frame");

    a_reset_clears_output: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid survived reset");

endmodule
